@@ src/piecewise_linear_interpolator_top_assert.svh @@
// Assertion macros for the piecewise-linear interpolator top level.
// Expects clk and arst_n in the scope of the including module.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PLI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pli_pkg.sv @@
// Shared types, codes and constants of the piecewise-linear interpolator.
// No dependencies; used by the channel interfaces and the top level.
package pli_pkg;

	localparam int PLI_TABLE_DEPTH = 256;

	// Signed Q16.16 value
	typedef logic signed [31:0] q16_t;
	typedef logic [7:0]         slot_t;
	typedef logic [8:0]         count_t;
	typedef logic [0:0]         cfg_idx_t;

	// Configuration register indexes
	localparam cfg_idx_t REG_POINT_COUNT   = 1'b0;
	localparam cfg_idx_t REG_DEFAULT_VALUE = 1'b1;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Arithmetic widths: 33-bit magnitudes, 66-bit product, 40-bit quotient
	localparam int MAG_W  = 33;
	localparam int PROD_W = 2 * MAG_W;
	localparam int QUO_W  = 40;
	localparam int RES_W  = QUO_W + 2;
	localparam int CNT_W  = $clog2(PROD_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LAST,
		ST_FIRST,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_DONE
	} pli_state_t;

endpackage

@@ src/pli_in_if.sv @@
// Input item channel of the piecewise-linear interpolator.
// Depends on pli_pkg.
interface pli_in_if;
	import pli_pkg::*;

	logic  valid;
	logic  ready;
	logic  operation;
	slot_t entry_index;
	q16_t  entry_x;
	q16_t  entry_y;
	q16_t  query_x;
	logic  batch_end;

	modport source (output valid, operation, entry_index, entry_x, entry_y, query_x,
		batch_end, input ready);
	modport sink (input valid, operation, entry_index, entry_x, entry_y, query_x,
		batch_end, output ready);
endinterface

@@ src/pli_out_if.sv @@
// Result channel of the piecewise-linear interpolator.
// Depends on pli_pkg.
interface pli_out_if;
	import pli_pkg::*;

	logic valid;
	logic ready;
	q16_t interpolated_y;
	logic out_of_range;
	logic batch_end_out;

	modport source (output valid, interpolated_y, out_of_range, batch_end_out, input ready);
	modport sink (input valid, interpolated_y, out_of_range, batch_end_out, output ready);
endinterface

@@ src/pli_cfg_if.sv @@
// Configuration write channel of the piecewise-linear interpolator.
// Depends on pli_pkg.
interface pli_cfg_if;
	import pli_pkg::*;

	logic        valid;
	logic        ready;
	cfg_idx_t    index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/piecewise_linear_interpolator_top.sv @@
// Piecewise-linear interpolator: breakpoint table, linear search and a shared
// add/subtract unit for the multiply and divide. Depends on pli_pkg,
// pli_in_if, pli_out_if, pli_cfg_if and the assertion macro header.
//
// A write beat stores one breakpoint (x, y); slots at or above TABLE_DEPTH are
// dropped. A query beat walks the table and returns one result beat. With fewer
// than two points in use, or a query outside first..last x, the default value
// comes back with out_of_range set. Otherwise the first slot j >= 1 with
// query_x <= x[j] is found by a linear scan, one slot per cycle through the
// table's single read port, and y[j-1] + dx*dy/span is formed on one 34-bit
// adder: a shift-add multiply, then a restoring divide (truncating toward zero).
// A zero span skips the arithmetic. The input is not ready while a query is in
// work; a finished result sits in an output register, so the next item is taken
// while it waits. Table contents are undefined until written and must not be
// queried before then. Configuration writes are always ready.
`include "piecewise_linear_interpolator_top_assert.svh"

module piecewise_linear_interpolator_top #(
	parameter int TABLE_DEPTH = pli_pkg::PLI_TABLE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	pli_in_if.sink     item,
	pli_out_if.source  result,
	pli_cfg_if.sink    cfg
);
	import pli_pkg::*;

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int NW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (NW > 9) ? NW : 9;

	function automatic logic [MAG_W-1:0] mag33(input logic [MAG_W-1:0] v);
		mag33 = v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
	endfunction

	// Control state
	pli_state_t state_q, state_d;
	count_t     point_count_q;
	q16_t       default_q;
	logic       res_valid_q;

	// Breakpoint table
	q16_t       mem_x [TABLE_DEPTH];
	q16_t       mem_y [TABLE_DEPTH];
	q16_t       rd_x_q, rd_y_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic       wr_en;

	// Query datapath
	logic [NW-1:0]     n_c, n_q;
	logic [AW-1:0]     j_q;
	q16_t              qx_q, xprev_q, yprev_q;
	logic              batch_q;
	logic [PROD_W-1:0] prod_q;
	logic [MAG_W-1:0]  b_q, d_q, rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic              big_q, neg_q;
	logic [CNT_W-1:0]  cnt_q;
	q16_t              fin_y_q;
	logic              fin_oor_q;
	q16_t              res_y_q;
	logic              res_oor_q, res_be_q;

	logic              accept_q;
	logic              scan_hit;
	logic              out_load;
	logic signed [MAG_W-1:0] dx_c, dy_c, span_c;

	// Shared add/subtract unit
	logic [MAG_W:0]   alu_a, alu_b;
	logic             alu_sub;
	logic [MAG_W+1:0] alu_sum;
	logic             alu_ge;

	// Final sum and saturation
	logic [QUO_W:0]   qv_c;
	logic [RES_W-1:0] delta_c, sum_c;
	q16_t             sat_c;

	assign item.ready  = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign accept_q    = item.valid && item.ready && (item.operation == OP_QUERY);

	assign wr_en   = item.valid && item.ready && (item.operation == OP_WRITE)
		&& (CMPW'(item.entry_index) < CMPW'(TABLE_DEPTH));
	assign wr_addr = AW'(item.entry_index);

	// Points in use, clamped to the table depth
	assign n_c = (CMPW'(point_count_q) > CMPW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
		: NW'(point_count_q);

	assign dx_c   = {qx_q[31], qx_q} - {xprev_q[31], xprev_q};
	assign dy_c   = {rd_y_q[31], rd_y_q} - {yprev_q[31], yprev_q};
	assign span_c = {rd_x_q[31], rd_x_q} - {xprev_q[31], xprev_q};

	// Stop at the first x[j] at or above the query, or at the last point
	assign scan_hit = (qx_q <= rd_x_q) || ((NW'(j_q) + NW'(1)) == n_q);

	assign alu_sum = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
		+ (MAG_W+2)'(alu_sub);
	assign alu_ge  = ~alu_sum[MAG_W+1];

	// Quotient clamps to 2^40 when it overflows 40 bits
	assign qv_c    = big_q ? ((QUO_W+1)'(1) << QUO_W) : {1'b0, quo_q};
	assign delta_c = neg_q ? (RES_W'(0) - {1'b0, qv_c}) : {1'b0, qv_c};
	assign sum_c   = {{(RES_W-32){yprev_q[31]}}, yprev_q} + delta_c;
	assign sat_c   = (sum_c[RES_W-1:31] == {(RES_W-31){sum_c[31]}}) ? sum_c[31:0]
		: (sum_c[RES_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

	assign out_load = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = AW'(n_c - NW'(1));
				if (accept_q) begin
					state_d = (n_c < NW'(2)) ? ST_DONE : ST_LAST;
				end
			end
			ST_LAST: begin
				rd_addr = '0;
				state_d = (qx_q > rd_x_q) ? ST_DONE : ST_FIRST;
			end
			ST_FIRST: begin
				rd_addr = AW'(1);
				state_d = (qx_q < rd_x_q) ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				rd_addr = j_q + AW'(1);
				if (scan_hit) begin
					state_d = (span_c == '0) ? ST_SUM : ST_MUL;
				end
			end
			ST_MUL: begin
				alu_a = {1'b0, prod_q[PROD_W-1:MAG_W]};
				alu_b = {1'b0, b_q};
				if (cnt_q == '0) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				alu_a   = {rem_q, prod_q[PROD_W-1]};
				alu_b   = {1'b0, d_q};
				alu_sub = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= '0;
			default_q     <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_POINT_COUNT:   point_count_q <= cfg.data[8:0];
					REG_DEFAULT_VALUE: default_q     <= cfg.data;
					default: ;
				endcase
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= item.entry_x;
			mem_y[wr_addr] <= item.entry_y;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept_q) begin
					qx_q      <= item.query_x;
					batch_q   <= item.batch_end;
					n_q       <= n_c;
					fin_y_q   <= default_q;
					fin_oor_q <= 1'b1;
				end
			end
			ST_FIRST: begin
				xprev_q <= rd_x_q;
				yprev_q <= rd_y_q;
				j_q     <= AW'(1);
			end
			ST_SCAN: begin
				if (!scan_hit) begin
					xprev_q <= rd_x_q;
					yprev_q <= rd_y_q;
					j_q     <= j_q + AW'(1);
				end else begin
					prod_q <= {{MAG_W{1'b0}}, mag33(dx_c)};
					b_q    <= mag33(dy_c);
					d_q    <= mag33(span_c);
					neg_q  <= dx_c[MAG_W-1] ^ dy_c[MAG_W-1] ^ span_c[MAG_W-1];
					cnt_q  <= CNT_W'(MAG_W - 1);
					quo_q  <= '0;
					big_q  <= 1'b0;
				end
			end
			ST_MUL: begin
				// Shift-add: add multiplicand into the upper half when the low bit is set
				if (prod_q[0]) begin
					prod_q <= {alu_sum[MAG_W:0], prod_q[MAG_W-1:1]};
				end else begin
					prod_q <= {1'b0, prod_q[PROD_W-1:MAG_W], prod_q[MAG_W-1:1]};
				end
				if (cnt_q == '0) begin
					cnt_q <= CNT_W'(PROD_W - 1);
					rem_q <= '0;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_DIV: begin
				// Restoring divide, one quotient bit per cycle, MSB first
				rem_q  <= alu_ge ? alu_sum[MAG_W-1:0] : alu_a[MAG_W-1:0];
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				quo_q  <= {quo_q[QUO_W-2:0], alu_ge};
				if (alu_ge && (cnt_q >= CNT_W'(QUO_W))) begin
					big_q <= 1'b1;
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_SUM: begin
				fin_y_q   <= sat_c;
				fin_oor_q <= 1'b0;
			end
			default: ;
		endcase
		if (out_load) begin
			res_y_q   <= fin_y_q;
			res_oor_q <= fin_oor_q;
			res_be_q  <= batch_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.interpolated_y = res_y_q;
	assign result.out_of_range   = res_oor_q;
	assign result.batch_end_out  = res_be_q;

	`PLI_ASSERT_NEXT(a_query_leaves_idle, accept_q, state_q != ST_IDLE, "query beat did not start work")
	`PLI_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, (j_q != '0) && (NW'(j_q) < n_q), "scan slot outside points in use")
	`PLI_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, d_q != '0, "divide by zero span")

endmodule
